/* design/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants for the Huffman code bit packer
// Item codes, field widths and default sizes used by the packer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN     = 32;
  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int SYM_W            = 8;
  localparam int BYTE_W           = 8;
  localparam int IN_DATA_W        = 48;
  localparam int MAX_BYTES        = 4;

  // Longest length kept in the table; also bounded by the code field width.
  localparam int CODE_LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

endpackage

`default_nettype wire

/* design/huffman_code_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit: Huffman code table and MSB-first bit packer
// Loads per-symbol codes, packs encoded symbols into bytes, flushes the tail.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser       tlast
//  s_axis    in   symbol, code_bits, code_length         operation   -
//  m_axis    out  out_byte                               -           last
//
//  An item is taken every cycle unless the packing stage is held; its table read
//  is registered; packing then hands up to four bytes to a four-byte buffer.
//  The byte-wide output sets the rate: a multi-byte encode holds packing till
//  the buffer is on its last byte, so one byte per cycle flows while m_axis
//  is ready; an m_axis stall backs up into s_axis_tready. Reset clears the
//  length valid bits at once (no clearing pass); the code memory is left unset.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [7:0] out_byte
  output logic [BYTE_W-1:0]         m_axis_tdata,
  output logic                      m_axis_tlast
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Input side decode
  logic [SYM_W-1:0]  in_sym;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  in_len_clip;
  logic [IDX_W-1:0]  in_idx;
  logic              in_range;
  logic              s_accept;
  op_t               in_op;

  assign in_sym   = s_axis_tdata[SYM_W-1:0];
  assign in_code  = s_axis_tdata[SYM_W+CODE_W-1:SYM_W];
  assign in_len   = s_axis_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];
  assign in_op    = op_t'(s_axis_tuser);
  assign in_idx   = in_sym[IDX_W-1:0];
  assign in_range = ({1'b0, in_sym} < (SYM_W+1)'(SYMBOL_COUNT));
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign in_len_clip = (in_len > LEN_W'(CODE_LEN_LIM)) ? LEN_W'(CODE_LEN_LIM) : in_len;

  // Code table memories; a length entry counts only once its valid bit is set
  logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_vld;

  // Packing stage registers
  logic              s1_valid;
  op_t               s1_op;
  logic              s1_range;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (in_op == OP_LOAD && in_range) begin
        code_mem[in_idx] <= in_code;
        len_mem[in_idx]  <= in_len_clip;
      end
      rd_code  <= code_mem[in_idx];
      rd_len   <= len_mem[in_idx];
      rd_vld   <= len_vld[in_idx];
      s1_op    <= in_op;
      s1_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
    end else if (s_accept && in_op == OP_LOAD && in_range) begin
      len_vld[in_idx] <= 1'b1;
    end
  end

  // Pending bits and output buffer
  logic [6:0]        pend_bits;
  logic [2:0]        pend_cnt;
  logic [BYTE_W-1:0] obuf [MAX_BYTES];
  logic [2:0]        obuf_cnt;

  // Packing logic
  logic [LEN_W-1:0]  len_eff;
  logic [CODE_W-1:0] code_mask;
  logic [CODE_W-1:0] code_m;
  logic [38:0]       acc;
  logic [5:0]        total;
  logic [39:0]       aligned;
  logic              enc_hit;
  logic              flush_hit;
  logic [2:0]        n_bytes;
  logic [BYTE_W-1:0] new_bytes [MAX_BYTES];
  logic [6:0]        pend_bits_next;
  logic [2:0]        pend_cnt_next;
  logic [BYTE_W-1:0] flush_byte;
  logic              buf_free;
  logic              s1_adv;
  logic              m_accept;

  always_comb begin
    len_eff   = (rd_vld && s1_range) ? rd_len : '0;
    code_mask = {CODE_W{1'b1}} >> (6'd32 - len_eff);
    code_m    = rd_code & code_mask;
    acc       = ({32'b0, pend_bits} << len_eff) | {7'b0, code_m};
    total     = {3'b0, pend_cnt} + len_eff;
    aligned   = {1'b0, acc} << (6'd40 - total);
    enc_hit   = (s1_op == OP_ENCODE) && (len_eff != '0);
    flush_hit = (s1_op == OP_FLUSH) && (pend_cnt != '0);
    flush_byte = BYTE_W'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt}));

    for (int k = 0; k < MAX_BYTES; k++) begin
      new_bytes[k] = aligned[39-8*k -: 8];
    end

    n_bytes        = '0;
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    case (s1_op)
      OP_ENCODE: begin
        if (enc_hit) begin
          n_bytes        = total[5:3];
          pend_cnt_next  = total[2:0];
          pend_bits_next = acc[6:0] & ~(7'h7F << total[2:0]);
        end
      end
      OP_FLUSH: begin
        if (flush_hit) begin
          n_bytes        = 3'd1;
          new_bytes[0]   = flush_byte;
          pend_cnt_next  = '0;
          pend_bits_next = '0;
        end
      end
      default: begin
        n_bytes = '0;
      end
    endcase
  end

  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign buf_free      = (obuf_cnt == 3'd0) || (obuf_cnt == 3'd1 && m_axis_tready);
  assign s1_adv        = s1_valid && ((n_bytes == 3'd0) || buf_free);
  // Take nothing while reset is held
  assign s_axis_tready = !rst && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        pend_bits <= pend_bits_next;
        pend_cnt  <= pend_cnt_next;
      end
    end
  end

  // Drain the buffer from entry 0, shifting down on each output item
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_cnt <= '0;
    end else if (s1_adv && n_bytes != 3'd0) begin
      obuf_cnt <= n_bytes;
    end else if (m_accept) begin
      obuf_cnt <= obuf_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && n_bytes != 3'd0) begin
      for (int k = 0; k < MAX_BYTES; k++) begin
        obuf[k] <= new_bytes[k];
      end
    end else if (m_accept) begin
      for (int k = 0; k < MAX_BYTES - 1; k++) begin
        obuf[k] <= obuf[k+1];
      end
    end
  end

  assign m_axis_tvalid = (obuf_cnt != 3'd0);
  assign m_axis_tdata  = obuf[0];
  assign m_axis_tlast  = (obuf_cnt == 3'd1);

endmodule

`default_nettype wire

/* design/hcbp_checker.sv */
// ----------------------------------------------------------------------------
// hcbp_checker: port-level checks for the Huffman code bit packer
// Watches the stream ports and flags handshake or sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_checker
  import hcbp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [BYTE_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tlast
);

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // Reset leaves nothing to send
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // With the output empty the packer never back-pressures the input
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output empty");

  // Bytes of one item follow without a gap until the last one
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a run of output bytes");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: Huffman code bit packer check
// Loads code table entries, encodes symbols and flushes the tail through the
// s_axis port. A local predictor works out each packed byte, and a monitor on
// m_axis checks every byte against it. Bursty sending, a stalling receiver,
// one long hold-off and a full drain put the pipeline through its paces.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import hcbp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } packed_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = OP_LOAD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;

  // predictor state
  logic [CODE_W-1:0] code_store [SYMBOL_COUNT_DEF];
  logic [LEN_W-1:0]  len_store  [SYMBOL_COUNT_DEF];
  logic [6:0]        tail_bits = '0;
  int unsigned       tail_count = 0;
  packed_byte_t      expected_bytes [$];
  int unsigned       live_symbols [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_len = 0;
  logic        hold_start = 1'b0;

  always #6 clk = ~clk;

  huffman_code_bit_packer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Work out the bytes one accepted item yields and queue them.
  task automatic pack_predict(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    int unsigned  l;
    logic [63:0]  code;
    logic [63:0]  acc;
    int unsigned  total;
    int unsigned  n;
    packed_byte_t r;
    begin
      case (op)
        OP_LOAD: begin
          l = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
          if (l > CODE_W) l = CODE_W;
          code_store[sym] = bits;
          len_store[sym]  = LEN_W'(l);
        end
        OP_ENCODE: begin
          l = len_store[sym];
          if (l != 0) begin
            code = {32'b0, code_store[sym]};
            if (l < 32) code &= (64'd1 << l) - 64'd1;
            acc = ({57'b0, tail_bits} << l) | code;
            total = tail_count + l;
            n = 0;
            while (total >= 8 && n < MAX_BYTES) begin
              total -= 8;
              r.out_byte = BYTE_W'(acc >> total);
              r.last = (total < 8);
              expected_bytes.push_back(r);
              n++;
            end
            tail_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
            tail_count = total;
          end
        end
        OP_FLUSH: begin
          if (tail_count != 0) begin
            r.out_byte = BYTE_W'({tail_bits, 1'b0} << (7 - tail_count));
            r.last = 1'b1;
            expected_bytes.push_back(r);
            tail_bits  = '0;
            tail_count = 0;
          end
        end
        default: ;
      endcase
    end
  endtask

  // Offer one item in the current burst; returns at the falling edge after acceptance.
  task automatic send_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    int unsigned gap;
    begin
      gap = 0;
      if (burst_left == 0) begin
        gap = $urandom_range(6, 1);
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 15) : $urandom_range(8, 1);
      end
      burst_left--;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {2'b00, len, bits, sym};
      s_axis_tuser  <= op;
      do @(posedge clk); while (!s_axis_tready);
      pack_predict(op, sym, bits, len);
      if (op == OP_LOAD && len != 0) live_symbols.push_back(sym);
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    begin
      s_axis_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // m_axis monitor
  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %02h (last %0b)", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Receiver: switches between free running, patchy and mostly stalled stretches.
  always @(negedge clk) begin
    static int unsigned hold_left = 0;
    static int unsigned mode = 0;
    static int unsigned mode_left = 0;
    if (hold_start) begin
      hold_left = hold_len;
      hold_start = 1'b0;
    end
    if (mode_left == 0) begin
      mode = $urandom_range(2);
      mode_left = $urandom_range(60, 10);
    end
    mode_left--;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(1) == 0);
        default: m_axis_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned roll;
    begin
      roll = $urandom_range(19);
      if (roll == 0) pick_length = '0;
      else if (roll == 1) pick_length = LEN_W'($urandom_range(63, 32));
      else if (roll < 5) pick_length = LEN_W'($urandom_range(31, 17));
      else pick_length = LEN_W'($urandom_range(16, 1));
    end
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    begin
      if (live_symbols.size() != 0 && $urandom_range(9) != 0)
        pick_symbol = SYM_W'(live_symbols[$urandom_range(live_symbols.size() - 1)]);
      else
        pick_symbol = SYM_W'($urandom_range(255));
    end
  endfunction

  task automatic test_directed();
    begin
      send_item(OP_LOAD, 8'd0,   32'h0000_0001, 6'd1);
      send_item(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
      send_item(OP_LOAD, 8'd1,   32'h0000_0000, 6'd32);
      // bits above the length must not leak into the stream
      send_item(OP_LOAD, 8'd2,   32'hFFFF_FF55, 6'd7);
      // over-long lengths are cut to the limit
      send_item(OP_LOAD, 8'd3,   32'hA5A5_A5A5, 6'd40);
      send_item(OP_LOAD, 8'd4,   32'h1234_5678, 6'd63);
      send_item(OP_LOAD, 8'd5,   32'hDEAD_BEEF, 6'd0);
      send_item(OP_ENCODE, 8'd0,   '0, '0);
      send_item(OP_ENCODE, 8'd255, '0, '0);
      send_item(OP_ENCODE, 8'd1,   '0, '0);
      send_item(OP_ENCODE, 8'd2,   '0, '0);
      send_item(OP_ENCODE, 8'd5,   32'hFFFF_FFFF, 6'h3F);
      send_item(OP_ENCODE, 8'd200, '0, '0);
      send_item(OP_ENCODE, 8'd3,   '0, '0);
      send_item(OP_ENCODE, 8'd4,   '0, '0);
      send_item(OP_FLUSH,  8'd0,   '0, '0);
      send_item(OP_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'h3F);
      send_item(OP_UNUSED, 8'hAA,  32'h5555_AAAA, 6'd21);
      send_item(OP_ENCODE, 8'd0,   '0, '0);
      send_item(OP_ENCODE, 8'd0,   '0, '0);
      send_item(OP_FLUSH,  8'd7,   '0, '0);
    end
  endtask

  // Frames of table loads, encodes and a closing flush, with noise mixed in.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned i;
    int unsigned runs;
    begin
      sent = 0;
      while (sent < 80) begin
        for (i = 0; i < $urandom_range(5, 1); i++) begin
          send_item(OP_LOAD, SYM_W'($urandom_range(255)), $urandom, pick_length());
          sent++;
        end
        runs = $urandom_range(16, 4);
        for (i = 0; i < runs; i++) begin
          case ($urandom_range(19))
            0:       send_item(OP_UNUSED, SYM_W'($urandom_range(255)), $urandom,
                               LEN_W'($urandom_range(63)));
            1:       send_item(OP_FLUSH, SYM_W'($urandom_range(255)), $urandom,
                               LEN_W'($urandom_range(63)));
            2:       send_item(OP_LOAD, pick_symbol(), $urandom, pick_length());
            default: send_item(OP_ENCODE, pick_symbol(), $urandom,
                               LEN_W'($urandom_range(63)));
          endcase
          sent++;
        end
        send_item(OP_FLUSH, '0, '0, '0);
        // an empty flush now and then
        if ($urandom_range(3) == 0) send_item(OP_FLUSH, '0, '0, '0);
        sent += 2;
      end
    end
  endtask

  // Hold the receiver off while long codes keep coming, so the input backs up.
  task automatic test_output_holdoff();
    int unsigned i;
    begin
      send_item(OP_LOAD, 8'd17, $urandom, 6'd32);
      send_item(OP_LOAD, 8'd18, $urandom, 6'd29);
      hold_len = 250;
      hold_start = 1'b1;
      burst_left = 1000;
      for (i = 0; i < 30; i++)
        send_item(OP_ENCODE, (i % 2 == 0) ? 8'd17 : 8'd18, '0, '0);
      send_item(OP_FLUSH, '0, '0, '0);
      burst_left = 0;
    end
  endtask

  // Let everything drain, then resume from an idle block.
  task automatic test_resume_after_drain();
    int unsigned i;
    begin
      wait_drained();
      for (i = 0; i < 12; i++)
        send_item(OP_ENCODE, pick_symbol(), '0, '0);
      send_item(OP_FLUSH, '0, '0, '0);
    end
  endtask

  initial begin
    for (int s = 0; s < SYMBOL_COUNT_DEF; s++) begin
      len_store[s]  = '0;
      code_store[s] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_frames();
    test_output_holdoff();
    test_resume_after_drain();
    wait_drained();
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
